// ===== hdl/mfdl_pkg.sv =====
`default_nettype none

package mfdl_pkg;

  localparam int unsigned DEFAULT_DEPTH = 131072;

  localparam int SMP_W   = 16;
  localparam int STEP_W  = 5;
  localparam int OPA_W   = 33;
  localparam int OPB_W   = 19;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int RND_W   = ACC_W - 16;
  localparam int DQ_W    = 36;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd4;

  localparam logic [17:0] RST_SAMPLE_RATE = 18'd48000;
  localparam logic [15:0] RST_SMOOTH_COEF = 16'd66;
  localparam logic [15:0] RST_FEEDBACK    = 16'd0;
  localparam logic [16:0] RST_WET_MIX     = 17'd32768;

  // 3 ms and 2 ms in Q2.30, 0.95 in Q0.16
  localparam logic [31:0] MOD_BASE_Q30 = 32'd3221225;
  localparam logic [21:0] MOD_SPAN_Q30 = 22'd2147484;
  localparam logic [15:0] FB_MAX_Q16   = 16'd62259;
  localparam logic [16:0] ONE_Q16      = 17'h10000;

  typedef enum logic [3:0] {
    A_FB, A_SPAN, A_SMOOTH, A_TARGET, A_AUDIO, A_LAST, A_S0, A_DIFF, A_RD
  } opa_e;

  typedef enum logic [3:0] {
    B_FBMAX, B_MOD2, B_DRYCOEF, B_COEF, B_RATE, B_ONE, B_GAIN, B_FRAC, B_DRYMIX, B_WET
  } opb_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_e;

  typedef enum logic [2:0] {
    WB_NONE, WB_GAIN, WB_TARGET, WB_SMOOTH, WB_DELAY, WB_STORE, WB_READ, WB_MIX
  } wb_e;

  typedef enum logic [1:0] {CAP_NONE, CAP_S0, CAP_S1} cap_e;
  typedef enum logic [1:0] {JMP_NONE, JMP_ALWAYS, JMP_MODE} jmp_e;
  typedef enum logic {RA_TAP0, RA_TAP1} ra_e;

  typedef struct packed {
    opa_e              a_sel;
    opb_e              b_sel;
    acc_e              acc;
    wb_e               wb;
    ra_e               ra;
    cap_e              cap;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
    logic              fin;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{
    a_sel:  A_FB,
    b_sel:  B_FBMAX,
    acc:    ACC_HOLD,
    wb:     WB_NONE,
    ra:     RA_TAP0,
    cap:    CAP_NONE,
    jmp:    JMP_NONE,
    target: '0,
    fin:    1'b0
  };

endpackage

`default_nettype wire

// ===== hdl/mfdl_ram.sv =====
`default_nettype none

module mfdl_ram
  import mfdl_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [SMP_W-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [SMP_W-1:0]  rdata_o
);

  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/mfdl_seq.sv =====
`default_nettype none

module mfdl_seq
  import mfdl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic mode_i,
  input  logic hold_i,
  output logic busy_o,
  output ctl_t ctl_o
);

  localparam logic [STEP_W-1:0] UA_MOD    = 5'd3;
  localparam logic [STEP_W-1:0] UA_SMOOTH = 5'd6;

  logic [STEP_W-1:0] step_q, step_d;
  logic              run_q, run_d;

  // Product issued in one step is accumulated in the next; a writeback
  // reads the accumulator the step after that.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] a);
    ctl_t c;
    c = CTL_NOP;
    case (a)
      5'd0: begin
        c.a_sel = A_FB;     c.b_sel = B_FBMAX;
        c.jmp   = JMP_MODE; c.target = UA_MOD;
      end
      5'd1: c.acc = ACC_LOAD;
      5'd2: begin
        c.wb = WB_GAIN; c.jmp = JMP_ALWAYS; c.target = UA_SMOOTH;
      end
      5'd3: begin
        c.a_sel = A_SPAN; c.b_sel = B_MOD2;
      end
      5'd4: c.acc = ACC_LOAD;
      5'd5: c.wb = WB_TARGET;
      5'd6: begin
        c.a_sel = A_SMOOTH; c.b_sel = B_DRYCOEF;
      end
      5'd7: begin
        c.a_sel = A_TARGET; c.b_sel = B_COEF; c.acc = ACC_LOAD;
      end
      5'd8: c.acc = ACC_ADD;
      5'd9: c.wb = WB_SMOOTH;
      5'd10: begin
        c.a_sel = A_SMOOTH; c.b_sel = B_RATE;
      end
      5'd11: c.acc = ACC_LOAD;
      5'd12: c.wb = WB_DELAY;
      5'd13: begin
        c.ra = RA_TAP0; c.a_sel = A_AUDIO; c.b_sel = B_ONE;
      end
      5'd14: begin
        c.ra    = RA_TAP1; c.cap   = CAP_S0;
        c.a_sel = A_LAST;  c.b_sel = B_GAIN; c.acc = ACC_LOAD;
      end
      5'd15: begin
        c.cap = CAP_S1; c.a_sel = A_S0; c.b_sel = B_ONE; c.acc = ACC_ADD;
      end
      5'd16: begin
        c.wb = WB_STORE; c.a_sel = A_DIFF; c.b_sel = B_FRAC; c.acc = ACC_LOAD;
      end
      5'd17: c.acc = ACC_ADD;
      5'd18: begin
        c.wb = WB_READ; c.a_sel = A_AUDIO; c.b_sel = B_DRYMIX;
      end
      5'd19: begin
        c.a_sel = A_RD; c.b_sel = B_WET; c.acc = ACC_LOAD;
      end
      5'd20: c.acc = ACC_ADD;
      5'd21: begin
        c.wb = WB_MIX; c.fin = 1'b1;
      end
      default: c = CTL_NOP;
    endcase
    return c;
  endfunction

  assign ctl_o  = run_q ? ucode(step_q) : CTL_NOP;
  assign busy_o = run_q;

  always_comb begin
    step_d = step_q;
    run_d  = run_q;
    if (start_i) begin
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q && !hold_i) begin
      if (ctl_o.fin) begin
        run_d = 1'b0;
      end else if (ctl_o.jmp == JMP_ALWAYS || (ctl_o.jmp == JMP_MODE && mode_i)) begin
        step_d = ctl_o.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/modulated_fractional_delay_line_top.sv =====
`default_nettype none

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: audio_in, delay_time, modulation;
//                                              tlast: block_last
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: audio_out; tlast: block_end
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// A sample is taken in an idle cycle, then the microprogram runs 19 steps in delay
// mode or 20 in modulation mode. Every product goes through the one shared 33x19
// multiplier, ten products per sample.
// After reset the delay store is swept to zero, one entry per clock
// (BUFFER_DEPTH entries, 131072 by default); s_axis_tready stays low meanwhile.
// The result sits in an output register; the next sample is taken while it waits,
// and only the final step of that sample holds if the old result is still pending.

module modulated_fractional_delay_line_top
  import mfdl_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,   // audio_in, delay_time, modulation, pad
  input  logic                  s_axis_tlast,   // block_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // audio_out
  output logic                  m_axis_tlast,   // block_end
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W+1)'(BUFFER_DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BUFFER_DEPTH - 1);
  localparam logic [DQ_W-1:0]   DQ_LO     = DQ_W'(65536);
  localparam logic [DQ_W-1:0]   DQ_HI     = DQ_W'(BUFFER_DEPTH - 2) << 16;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);
  localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'(32767);
  localparam logic signed [RND_W-1:0] SAT_MIN  = RND_W'(-32768);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_READY = 2'b10
  } state_e;

  function automatic logic [SMP_W-1:0] sat16(input logic signed [RND_W-1:0] v);
    if (v > SAT_MAX) begin
      return 16'h7FFF;
    end else if (v < SAT_MIN) begin
      return 16'h8000;
    end
    return v[SMP_W-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_addr_q;

  logic [17:0]         rate_q;
  logic [15:0]         coef_q;
  logic [15:0]         fb_q;
  logic [16:0]         wet_q;
  logic                mode_q;

  logic [SMP_W-1:0]    audio_q, modv_q, s0_q, s1_q, rd_q, last_rd_q;
  logic                blast_q;
  logic [31:0]         target_q, smooth_q;
  logic [15:0]         gain_q;
  logic [ADDR_W+15:0]  delay_q;
  logic [ADDR_W-1:0]   wp_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  logic                out_valid_q;
  logic [SMP_W-1:0]    out_data_q;
  logic                out_last_q;

  ctl_t                ctl;
  logic                busy, start, hold, wb_go;

  logic [16:0]         wet_sat, dry_mix, dry_coef, frac_w;
  logic [15:0]         frac;
  logic                frac_nz;
  logic [ADDR_W-1:0]   di, back, tap0, tap1, wp_next;
  logic [ADDR_W:0]     tap_sum, tap_red;
  logic [16:0]         diff;
  logic signed [OPA_W-1:0] a_op;
  logic signed [OPB_W-1:0] b_op;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [RND_W-1:0] r16;
  logic [SMP_W-1:0]    sat_r;
  logic [DQ_W-1:0]     dq_raw, dq_clamp;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [SMP_W-1:0]    ram_wdata, ram_rdata;

  assign s_axis_tready = (state_q == ST_READY) && !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // last step waits until the previous result has left
  assign hold  = (ctl.wb == WB_MIX) && out_valid_q && !m_axis_tready;
  assign wb_go = !hold;

  mfdl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_q),
    .hold_i  (hold),
    .busy_o  (busy),
    .ctl_o   (ctl)
  );

  // derived operands
  assign wet_sat  = (wet_q > ONE_Q16) ? ONE_Q16 : wet_q;
  assign dry_mix  = ONE_Q16 - wet_sat;
  assign dry_coef = ONE_Q16 - {1'b0, coef_q};
  assign frac     = delay_q[15:0];
  assign di       = delay_q[ADDR_W+15:16];
  assign frac_nz  = |frac;
  assign frac_w   = frac_nz ? (ONE_Q16 - {1'b0, frac}) : '0;
  assign back     = di + ADDR_W'(frac_nz);
  assign tap_sum  = {1'b0, wp_q} + DEPTH_X - {1'b0, back};
  assign tap_red  = tap_sum - DEPTH_X;
  assign tap0     = (tap_sum >= DEPTH_X) ? tap_red[ADDR_W-1:0] : tap_sum[ADDR_W-1:0];
  assign tap1     = (tap0 == ADDR_LAST) ? '0 : tap0 + 1'b1;
  assign wp_next  = (wp_q == ADDR_LAST) ? '0 : wp_q + 1'b1;
  assign diff     = {s1_q[15], s1_q} - {s0_q[15], s0_q};

  always_comb begin
    case (ctl.a_sel)
      A_FB:     a_op = {17'b0, fb_q};
      A_SPAN:   a_op = {11'b0, MOD_SPAN_Q30};
      A_SMOOTH: a_op = {1'b0, smooth_q};
      A_TARGET: a_op = {1'b0, target_q};
      A_AUDIO:  a_op = {{17{audio_q[15]}}, audio_q};
      A_LAST:   a_op = {{17{last_rd_q[15]}}, last_rd_q};
      A_S0:     a_op = {{17{s0_q[15]}}, s0_q};
      A_DIFF:   a_op = {{16{diff[16]}}, diff};
      A_RD:     a_op = {{17{rd_q[15]}}, rd_q};
      default:  a_op = '0;
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      B_FBMAX:   b_op = {3'b0, FB_MAX_Q16};
      B_MOD2:    b_op = {{2{modv_q[15]}}, modv_q, 1'b0};
      B_DRYCOEF: b_op = {2'b0, dry_coef};
      B_COEF:    b_op = {3'b0, coef_q};
      B_RATE:    b_op = {1'b0, rate_q};
      B_ONE:     b_op = {2'b0, ONE_Q16};
      B_GAIN:    b_op = {3'b0, gain_q};
      B_FRAC:    b_op = {2'b0, frac_w};
      B_DRYMIX:  b_op = {2'b0, dry_mix};
      B_WET:     b_op = {2'b0, wet_sat};
      default:   b_op = '0;
    endcase
  end

  assign prod_d = a_op * b_op;

  always_comb begin
    case (ctl.acc)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      default:  acc_d = acc_q;
    endcase
  end

  // round half up on 2^16, then saturate to Q1.15
  assign rnd_sum = acc_q + RND_HALF;
  assign r16     = rnd_sum[ACC_W-1:16];
  assign sat_r   = sat16(r16);

  assign dq_raw   = acc_q[DQ_W+13:14];
  assign dq_clamp = (dq_raw < DQ_LO) ? DQ_LO : ((dq_raw > DQ_HI) ? DQ_HI : dq_raw);

  // store port: zero sweep after reset, then the feedback write
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (ctl.wb == WB_STORE);
      ram_waddr = wp_q;
      ram_wdata = sat_r;
    end
  end

  assign ram_raddr = (ctl.ra == RA_TAP1) ? tap1 : tap0;

  mfdl_ram #(
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == ADDR_LAST) begin
          state_d = ST_READY;
        end
      end
      ST_READY: state_d = ST_READY;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      rate_q      <= RST_SAMPLE_RATE;
      coef_q      <= RST_SMOOTH_COEF;
      fb_q        <= RST_FEEDBACK;
      wet_q       <= RST_WET_MIX;
      mode_q      <= 1'b0;
      wp_q        <= '0;
      smooth_q    <= '0;
      last_rd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SAMPLE_RATE: rate_q <= cfg_data_i[17:0];
          REG_SMOOTH_COEF: coef_q <= cfg_data_i[15:0];
          REG_FEEDBACK:    fb_q   <= cfg_data_i[15:0];
          REG_WET_MIX:     wet_q  <= cfg_data_i[16:0];
          REG_MODE:        mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (ctl.wb == WB_SMOOTH) begin
        smooth_q <= r16[31:0];
      end

      if (ctl.wb == WB_MIX && wb_go) begin
        out_valid_q <= 1'b1;
        wp_q        <= wp_next;
        last_rd_q   <= rd_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;

    if (start) begin
      audio_q  <= s_axis_tdata[15:0];
      target_q <= {s_axis_tdata[33:16], 14'b0};
      modv_q   <= s_axis_tdata[49:34];
      blast_q  <= s_axis_tlast;
      gain_q   <= '0;
    end

    case (ctl.cap)
      CAP_S0:  s0_q <= ram_rdata;
      CAP_S1:  s1_q <= ram_rdata;
      default: ;
    endcase

    case (ctl.wb)
      WB_GAIN:   gain_q   <= r16[15:0];
      WB_TARGET: target_q <= MOD_BASE_Q30 + r16[31:0];
      WB_DELAY:  delay_q  <= dq_clamp[ADDR_W+15:0];
      WB_READ:   rd_q     <= sat_r;
      WB_MIX: begin
        if (wb_go) begin
          out_data_q <= sat_r;
          out_last_q <= blast_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
